// ----- design/vnd_pkg.sv -----
// shared types and constants for the vector distance block
`timescale 1ns / 1ps

package vnd_pkg;

    localparam int ELEM_W       = 16;
    localparam int TERM_W       = 2 * ELEM_W;
    localparam int SUM_W        = 46;
    localparam int OUT_W        = 28;
    localparam int ROOT_W       = SUM_W / 2;
    localparam int DIV_STEPS    = SUM_W;
    localparam int SQRT_STEPS   = SUM_W / 2;
    localparam int STEP_W       = $clog2(DIV_STEPS);
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 1;
    localparam int MAX_ELEMENTS_DEF = 4096;

    localparam logic [CFG_IDX_W-1:0] CFG_DISTANCE_KIND = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NORMALIZE     = 1'd1;

    typedef enum logic [2:0] {
        ST_ACCUM,
        ST_FLUSH,
        ST_DIV,
        ST_SQRT,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic take;
        logic flush;
        logic div_step;
        logic sqrt_step;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic kind;
        logic normalize;
        logic cnt_zero;
        logic out_free;
    } t_dp_sts;

endpackage

// ----- design/vnd_in_if.sv -----
// element pair channel
`timescale 1ns / 1ps

interface vnd_in_if
    import vnd_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [ELEM_W-1:0] elem_a;
    logic signed [ELEM_W-1:0] elem_b;
    logic                     last_element;

    modport source (output valid, elem_a, elem_b, last_element, input ready);
    modport sink   (input valid, elem_a, elem_b, last_element, output ready);
endinterface

// ----- design/vnd_out_if.sv -----
// distance result channel
`timescale 1ns / 1ps

interface vnd_out_if
    import vnd_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] distance;

    modport source (output valid, distance, input ready);
    modport sink   (input valid, distance, output ready);
endinterface

// ----- design/vnd_ctrl.sv -----
// controller state machine for the vector distance block
`timescale 1ns / 1ps

module vnd_ctrl
    import vnd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_in_last,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state              r_state;
    t_state              n_state;
    logic [STEP_W-1:0]   r_step;
    logic                w_div_end;
    logic                w_sqrt_end;

    assign w_div_end  = (r_step == STEP_W'(DIV_STEPS - 1));
    assign w_sqrt_end = (r_step == STEP_W'(SQRT_STEPS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_ACCUM;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state != n_state) begin
                r_step <= '0;
            end else if (r_state == ST_DIV || r_state == ST_SQRT) begin
                r_step <= r_step + 1'b1;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_ACCUM: begin
                if (i_in_valid && i_in_last) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (i_sts.normalize && !i_sts.cnt_zero) begin
                    n_state = ST_DIV;
                end else if (i_sts.kind) begin
                    n_state = ST_SQRT;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_DIV: begin
                if (w_div_end) begin
                    n_state = i_sts.kind ? ST_SQRT : ST_DONE;
                end
            end
            ST_SQRT: begin
                if (w_sqrt_end) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_sts.out_free) begin
                    n_state = ST_ACCUM;
                end
            end
            default: begin
                n_state = ST_ACCUM;
            end
        endcase
    end

    always_comb begin
        o_in_ready      = 1'b0;
        o_cmd           = '0;
        case (r_state)
            ST_ACCUM: begin
                o_in_ready = 1'b1;
                o_cmd.take = i_in_valid;
            end
            ST_FLUSH: begin
                o_cmd.flush = 1'b1;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
            end
            ST_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
            end
            ST_DONE: begin
                o_cmd.out_load = i_sts.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ----- design/vnd_datapath.sv -----
// accumulator, divider, square root and output register
`timescale 1ns / 1ps

module vnd_datapath
    import vnd_pkg::*;
#(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [CFG_DATA_W-1:0]    i_cfg_wdata,
    input  logic signed [ELEM_W-1:0] i_elem_a,
    input  logic signed [ELEM_W-1:0] i_elem_b,
    input  t_dp_cmd                  i_cmd,
    output t_dp_sts                  o_sts,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [OUT_W-1:0]         o_out_distance
);

    localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);

    logic                     r_kind;
    logic                     r_normalize;
    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         r_div;
    logic [CNT_W-1:0]         r_drem;
    logic [TERM_W-1:0]        r_term;
    logic                     r_term_vld;
    logic [SUM_W-1:0]         r_sum;
    logic [SUM_W-1:0]         r_work;
    logic [ROOT_W-1:0]        r_root;
    logic [ROOT_W:0]          r_srem;
    logic                     r_out_valid;
    logic [OUT_W-1:0]         r_out_distance;

    logic                     w_room;
    logic signed [ELEM_W:0]   w_diff;
    logic signed [ELEM_W:0]   w_neg;
    logic [ELEM_W-1:0]        w_mag;
    logic [TERM_W-1:0]        w_sq;
    logic [SUM_W:0]           w_sum_ext;
    logic [SUM_W-1:0]         w_sum_add;
    logic [CNT_W:0]           w_dsh;
    logic [CNT_W:0]           w_dsub;
    logic                     w_dge;
    logic [ROOT_W+2:0]        w_ssh;
    logic [ROOT_W+2:0]        w_trial;
    logic [ROOT_W+2:0]        w_ssub;
    logic                     w_sge;
    logic [OUT_W-1:0]         w_result;

    // term stage
    assign w_room = (r_count < CNT_W'(MAX_ELEMENTS));
    assign w_diff = {i_elem_a[ELEM_W-1], i_elem_a} - {i_elem_b[ELEM_W-1], i_elem_b};
    assign w_neg  = -w_diff;
    assign w_mag  = w_diff[ELEM_W] ? w_neg[ELEM_W-1:0] : w_diff[ELEM_W-1:0];
    assign w_sq   = w_mag * w_mag;

    // saturating accumulate
    assign w_sum_ext = {1'b0, r_sum} + (r_term_vld ? (SUM_W + 1)'(r_term) : '0);
    assign w_sum_add = w_sum_ext[SUM_W] ? '1 : w_sum_ext[SUM_W-1:0];

    // restoring divide, one quotient bit a step
    assign w_dsh  = {r_drem, r_work[SUM_W-1]};
    assign w_dsub = w_dsh - {1'b0, r_div};
    assign w_dge  = (w_dsh >= {1'b0, r_div});

    // square root, one root bit a step
    assign w_ssh   = {r_srem, r_work[SUM_W-1:SUM_W-2]};
    assign w_trial = {1'b0, r_root, 2'b01};
    assign w_ssub  = w_ssh - w_trial;
    assign w_sge   = (w_ssh >= w_trial);

    always_comb begin
        if (r_kind) begin
            w_result = OUT_W'(r_root);
        end else if (r_work[SUM_W-1:OUT_W] != '0) begin
            w_result = '1;
        end else begin
            w_result = r_work[OUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind      <= 1'b0;
            r_normalize <= 1'b0;
            r_count     <= '0;
            r_term_vld  <= 1'b0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_DISTANCE_KIND: r_kind      <= i_cfg_wdata[0];
                    CFG_NORMALIZE:     r_normalize <= i_cfg_wdata[0];
                    default:           r_kind      <= r_kind;
                endcase
            end

            if (i_cmd.flush) begin
                r_sum      <= '0;
                r_count    <= '0;
                r_term_vld <= 1'b0;
            end else begin
                r_sum      <= w_sum_add;
                r_term_vld <= i_cmd.take && w_room;
                if (i_cmd.take && w_room) begin
                    r_count <= r_count + 1'b1;
                end
            end

            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_term <= r_kind ? w_sq : TERM_W'(w_mag);
        end

        if (i_cmd.flush) begin
            r_work <= w_sum_add;
            r_div  <= r_count;
            r_drem <= '0;
            r_srem <= '0;
            r_root <= '0;
        end else if (i_cmd.div_step) begin
            r_work <= {r_work[SUM_W-2:0], w_dge};
            r_drem <= w_dge ? w_dsub[CNT_W-1:0] : w_dsh[CNT_W-1:0];
        end else if (i_cmd.sqrt_step) begin
            r_work <= {r_work[SUM_W-3:0], 2'b00};
            r_srem <= w_sge ? w_ssub[ROOT_W:0] : w_ssh[ROOT_W:0];
            r_root <= {r_root[ROOT_W-2:0], w_sge};
        end

        if (i_cmd.out_load) begin
            r_out_distance <= w_result;
        end
    end

    assign o_sts.kind      = r_kind;
    assign o_sts.normalize = r_normalize;
    assign o_sts.cnt_zero  = (r_count == '0);
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid    = r_out_valid;
    assign o_out_distance = r_out_distance;

endmodule

// ----- design/vector_norm_distance.sv -----
// top level of the L1 / L2 vector distance block
// after the last pair: flush, then divide (normalize, nonzero count), root (L2) and done states
// throughput: one element pair per cycle within a vector
// per vector the pair input stalls after the last pair through the finishing states,
// set by the bit-serial divider and the two-bit-per-step square root, longer while a result waits
// reset is synchronous, active low: clears the config registers, sum, count and output valid
`timescale 1ns / 1ps

module vector_norm_distance
    import vnd_pkg::*;
#(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    vnd_in_if.sink                i_pair,
    vnd_out_if.source             o_dist,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_dp_cmd          w_cmd;
    t_dp_sts          w_sts;
    logic             w_in_ready;
    logic             w_out_valid;
    logic [OUT_W-1:0] w_out_distance;

    vnd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_pair.valid),
        .i_in_last  (i_pair.last_element),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    vnd_datapath #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_elem_a       (i_pair.elem_a),
        .i_elem_b       (i_pair.elem_b),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .o_out_valid    (w_out_valid),
        .i_out_ready    (o_dist.ready),
        .o_out_distance (w_out_distance)
    );

    assign i_pair.ready    = w_in_ready;
    assign o_dist.valid    = w_out_valid;
    assign o_dist.distance = w_out_distance;

endmodule

// ----- design/vnd_checker.sv -----
// port checker for the vector distance block and its bind
`timescale 1ns / 1ps

module vnd_checker
    import vnd_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             i_in_ready,
    input logic             i_in_last,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic [OUT_W-1:0] i_out_distance
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_distance)))
        else $error("result changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // the last transfer of a vector stops the pair input for the finish
    a_last_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && i_in_last) |=> !i_in_ready)
        else $error("pair input open right after last pair");

    // a new result only follows a finishing phase with the input closed
    a_result_after_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(!i_in_ready))
        else $error("result without finishing phase");

endmodule

bind vector_norm_distance vnd_checker u_vnd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_pair.valid),
    .i_in_ready     (i_pair.ready),
    .i_in_last      (i_pair.last_element),
    .i_out_valid    (o_dist.valid),
    .i_out_ready    (o_dist.ready),
    .i_out_distance (o_dist.distance)
);

// ----- tb/tb_vector_norm_distance.sv -----
// self-checking testbench for the L1 / L2 vector distance block
`timescale 1ns / 1ps

module tb_vector_norm_distance;
    import vnd_pkg::*;

    localparam int MAX_PAIRS     = 4096;
    localparam int SETTLE_CYCLES = 80;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASES        = 8;
    localparam int PHASE_PAIRS   = 150;
    localparam int MAX_REPORTS   = 10;
    localparam int DIR_ROWS      = 20;

    localparam longint unsigned SUM_CAP = (64'd1 << SUM_W) - 64'd1;
    localparam longint unsigned OUT_CAP = (64'd1 << OUT_W) - 64'd1;

    localparam logic signed [ELEM_W-1:0] ELEM_MIN = 16'sh8000;
    localparam logic signed [ELEM_W-1:0] ELEM_MAX = 16'sh7fff;

    typedef enum logic {
        ROW_PAIR,
        ROW_CFG
    } t_row_kind;

    typedef struct packed {
        t_row_kind                kind;
        logic [CFG_IDX_W-1:0]     idx;
        logic [CFG_DATA_W-1:0]    val;
        logic signed [ELEM_W-1:0] a;
        logic signed [ELEM_W-1:0] b;
        logic                     last;
        logic                     known;
        logic [OUT_W-1:0]         want;
    } t_dir_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    vnd_in_if  pair_ch ();
    vnd_out_if dist_ch ();

    logic [OUT_W-1:0] pending_dist[$];
    logic [OUT_W-1:0] exp_dist;
    int               mismatch_cnt;

    // predictor state
    logic             kind_l2;
    logic             norm_on;
    longint unsigned  sum_acc;
    int               pair_cnt;

    // flow control
    bit               send_idle_en;
    bit               recv_idle_en;
    bit               hold_req;
    int               stall_left;

    t_dir_row         dir_rows [DIR_ROWS];

    vector_norm_distance #(
        .MAX_ELEMENTS(MAX_PAIRS)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pair     (pair_ch),
        .o_dist     (dist_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_wdata(cfg_wdata)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    function automatic longint unsigned root_floor(input longint unsigned x);
        longint unsigned r;
        longint unsigned t;
        r = 0;
        for (int i = 23; i >= 0; i--) begin
            t = r | (64'd1 << i);
            if (t * t <= x) begin
                r = t;
            end
        end
        return r;
    endfunction

    function automatic void accumulate_pair(input logic signed [ELEM_W-1:0] a,
                                            input logic signed [ELEM_W-1:0] b,
                                            input logic last,
                                            output logic emit,
                                            output logic [OUT_W-1:0] res_dist);
        longint          diff;
        longint unsigned mag;
        longint unsigned total;
        emit = 1'b0;
        res_dist = '0;
        if (pair_cnt < MAX_PAIRS) begin
            diff  = longint'(a) - longint'(b);
            mag   = (diff < 0) ? -diff : diff;
            total = sum_acc + (kind_l2 ? mag * mag : mag);
            sum_acc = (total > SUM_CAP) ? SUM_CAP : total;
            pair_cnt++;
        end
        if (last) begin
            total = sum_acc;
            if (norm_on && pair_cnt != 0) begin
                total = total / longint'(pair_cnt);
            end
            if (kind_l2) begin
                total = root_floor(total);
            end
            if (total > OUT_CAP) begin
                total = OUT_CAP;
            end
            res_dist = total[OUT_W-1:0];
            emit     = 1'b1;
            sum_acc  = 0;
            pair_cnt = 0;
        end
    endfunction

    task automatic note_error(input string msg);
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS) begin
            $display("%s", msg);
        end
    endtask

    task automatic send_pair(input logic signed [ELEM_W-1:0] a,
                             input logic signed [ELEM_W-1:0] b,
                             input logic last,
                             input logic known,
                             input logic [OUT_W-1:0] known_dist);
        logic             emit;
        logic [OUT_W-1:0] res_dist;
        @(negedge i_clk);
        if (send_idle_en && $urandom_range(0, 4) == 0) begin
            pair_ch.valid = 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge i_clk);
        end
        pair_ch.valid        = 1'b1;
        pair_ch.elem_a       = a;
        pair_ch.elem_b       = b;
        pair_ch.last_element = last;
        do @(posedge i_clk); while (!pair_ch.ready);
        accumulate_pair(a, b, last, emit, res_dist);
        if (emit) begin
            pending_dist.push_back(known ? known_dist : res_dist);
        end
    endtask

    task automatic drain_results(input int extra);
        @(negedge i_clk);
        pair_ch.valid = 1'b0;
        while (pending_dist.size() != 0) @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        case (idx)
            CFG_DISTANCE_KIND: kind_l2 = val[0];
            CFG_NORMALIZE:     norm_on = val[0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_we = 1'b0;
    endtask

    function automatic logic signed [ELEM_W-1:0] pick_elem();
        case ($urandom_range(0, 7))
            0:       return ELEM_MIN;
            1:       return ELEM_MAX;
            2:       return '0;
            3:       return ELEM_W'($signed($urandom_range(0, 31)) - 16);
            default: return ELEM_W'($urandom());
        endcase
    endfunction

    task automatic send_vector(input int len, input bit extreme);
        bit flip;
        for (int i = 0; i < len; i++) begin
            if (extreme) begin
                flip = $urandom_range(0, 1);
                send_pair(flip ? ELEM_MAX : ELEM_MIN, flip ? ELEM_MIN : ELEM_MAX,
                          i == len - 1, 1'b0, '0);
            end else begin
                send_pair(pick_elem(), pick_elem(), i == len - 1, 1'b0, '0);
            end
        end
    endtask

    // result side: random stalls, plus one long hold-off on request
    initial begin
        dist_ch.ready = 1'b0;
        stall_left    = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                dist_ch.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end
            if (stall_left != 0) begin
                dist_ch.ready = 1'b0;
                stall_left--;
            end else if (recv_idle_en && $urandom_range(0, 5) == 0) begin
                dist_ch.ready = 1'b0;
                stall_left    = $urandom_range(0, 8);
            end else begin
                dist_ch.ready = 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && dist_ch.valid && dist_ch.ready) begin
            if (pending_dist.size() == 0) begin
                note_error($sformatf("unexpected distance transfer: got %0d",
                                     dist_ch.distance));
            end else begin
                exp_dist = pending_dist.pop_front();
                if (exp_dist !== dist_ch.distance) begin
                    note_error($sformatf("distance mismatch: expected %0d, got %0d",
                                         exp_dist, dist_ch.distance));
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    initial begin
        int sent;
        int len;
        pair_ch.valid        = 1'b0;
        pair_ch.elem_a       = '0;
        pair_ch.elem_b       = '0;
        pair_ch.last_element = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = CFG_DISTANCE_KIND;
        cfg_wdata    = '0;
        i_rst_n      = 1'b0;
        mismatch_cnt = 0;
        kind_l2      = 1'b0;
        norm_on      = 1'b0;
        sum_acc      = 0;
        pair_cnt     = 0;
        send_idle_en = 1'b1;
        recv_idle_en = 1'b1;
        hold_req     = 1'b0;

        dir_rows = '{
            // reset state: L1, no normalize
            '{ROW_PAIR, CFG_DISTANCE_KIND, 1'b0, 16'sd0,   16'sd0,   1'b1, 1'b1, 28'd0},
            '{ROW_PAIR, CFG_DISTANCE_KIND, 1'b0, ELEM_MAX, ELEM_MIN, 1'b1, 1'b1, 28'd65535},
            '{ROW_PAIR, CFG_DISTANCE_KIND, 1'b0, ELEM_MIN, ELEM_MAX, 1'b1, 1'b1, 28'd65535},
            '{ROW_PAIR, CFG_DISTANCE_KIND, 1'b0, 16'sd100, -16'sd50, 1'b0, 1'b0, 28'd0},
            '{ROW_PAIR, CFG_DISTANCE_KIND, 1'b0, -16'sd1,  16'sd1,   1'b0, 1'b0, 28'd0},
            '{ROW_PAIR, CFG_DISTANCE_KIND, 1'b0, 16'sd5,   16'sd5,   1'b1, 1'b0, 28'd0},
            // L1 normalized
            '{ROW_CFG,  CFG_NORMALIZE,     1'b1, 16'sd0,   16'sd0,   1'b0, 1'b0, 28'd0},
            '{ROW_PAIR, CFG_DISTANCE_KIND, 1'b0, ELEM_MAX, ELEM_MIN, 1'b0, 1'b0, 28'd0},
            '{ROW_PAIR, CFG_DISTANCE_KIND, 1'b0, 16'sd0,   16'sd0,   1'b1, 1'b1, 28'd32767},
            // L2 normalized
            '{ROW_CFG,  CFG_DISTANCE_KIND, 1'b1, 16'sd0,   16'sd0,   1'b0, 1'b0, 28'd0},
            '{ROW_PAIR, CFG_DISTANCE_KIND, 1'b0, ELEM_MAX, ELEM_MIN, 1'b1, 1'b1, 28'd65535},
            '{ROW_PAIR, CFG_DISTANCE_KIND, 1'b0, 16'sd3,   16'sd0,   1'b0, 1'b0, 28'd0},
            '{ROW_PAIR, CFG_DISTANCE_KIND, 1'b0, 16'sd4,   16'sd0,   1'b1, 1'b0, 28'd0},
            // L2 plain
            '{ROW_CFG,  CFG_NORMALIZE,     1'b0, 16'sd0,   16'sd0,   1'b0, 1'b0, 28'd0},
            '{ROW_PAIR, CFG_DISTANCE_KIND, 1'b0, 16'sd3,   16'sd0,   1'b0, 1'b0, 28'd0},
            '{ROW_PAIR, CFG_DISTANCE_KIND, 1'b0, -16'sd4,  16'sd0,   1'b1, 1'b1, 28'd5},
            '{ROW_PAIR, CFG_DISTANCE_KIND, 1'b0, ELEM_MIN, ELEM_MIN, 1'b1, 1'b1, 28'd0},
            // kind switched mid-vector: squared term, then absolute term, no root
            '{ROW_PAIR, CFG_DISTANCE_KIND, 1'b0, 16'sd10,  16'sd0,   1'b0, 1'b0, 28'd0},
            '{ROW_CFG,  CFG_DISTANCE_KIND, 1'b0, 16'sd0,   16'sd0,   1'b0, 1'b0, 28'd0},
            '{ROW_PAIR, CFG_DISTANCE_KIND, 1'b0, 16'sd0,   16'sd10,  1'b1, 1'b1, 28'd110}
        };

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_CFG) begin
                drain_results(SETTLE_CYCLES);
                cfg_write(dir_rows[i].idx, dir_rows[i].val);
            end else begin
                send_pair(dir_rows[i].a, dir_rows[i].b, dir_rows[i].last,
                          dir_rows[i].known, dir_rows[i].want);
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            drain_results(SETTLE_CYCLES);
            cfg_write(CFG_DISTANCE_KIND, CFG_DATA_W'(ph % 2));
            cfg_write(CFG_NORMALIZE, CFG_DATA_W'((ph / 2) % 2));
            send_idle_en = (ph != PHASES - 1) && ($urandom_range(0, 3) != 0);
            recv_idle_en = (ph != PHASES - 1) && ($urandom_range(0, 3) != 0);
            if (ph == 0) begin
                // result side holds off while vectors keep coming
                @(posedge i_clk);
                hold_req = 1'b1;
            end
            sent = 0;
            while (sent < PHASE_PAIRS) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64)
                                                  : $urandom_range(1, 8);
                send_vector(len, $urandom_range(0, 15) == 0);
                sent += len;
            end
        end

        drain_results(2 * SETTLE_CYCLES);
        if (mismatch_cnt == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
